FILE: rtl/stable_priority_queue_macros.svh
// ----------------------------------------------------------------------------
// stable_priority_queue assertion macros
// shared property forms for the checker of the sorted queue
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication
`define SPQ_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// types and constants shared by the stable priority queue modules
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH   = 64;
   localparam int DEFAULT_TAG_BITS      = 16;
   localparam int DEFAULT_PRIORITY_BITS = 4;

   localparam int TAG_W  = 16;
   localparam int PRIO_W = 4;
   localparam int OCC_W  = 7;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } opcode_type;

   typedef struct packed {
      logic insert_en;
      logic remove_en;
   } cell_ctrl_type;

   typedef struct packed {
      logic              accepted;
      logic [TAG_W-1:0]  head_tag;
      logic [PRIO_W-1:0] head_priority;
      logic [OCC_W-1:0]  occupancy;
   } rsp_type;

endpackage

FILE: rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted shift chain: compares, takes new, left or right entry
// ----------------------------------------------------------------------------
module spq_cell #(
   parameter int TAG_BITS      = spq_pkg::DEFAULT_TAG_BITS,
   parameter int PRIORITY_BITS = spq_pkg::DEFAULT_PRIORITY_BITS,
   parameter int COUNT_BITS    = 7,
   parameter int CELL_INDEX    = 0
) (
   input  logic                     clock,
   input  spq_pkg::cell_ctrl_type   ctrl,
   input  logic [COUNT_BITS-1:0]    fill_count,
   input  logic [TAG_BITS-1:0]      new_tag,
   input  logic [PRIORITY_BITS-1:0] new_priority,
   input  logic                     left_hit,
   input  logic [TAG_BITS-1:0]      left_tag,
   input  logic [PRIORITY_BITS-1:0] left_priority,
   input  logic [TAG_BITS-1:0]      right_tag,
   input  logic [PRIORITY_BITS-1:0] right_priority,
   output logic                     hit,
   output logic [TAG_BITS-1:0]      slot_tag,
   output logic [PRIORITY_BITS-1:0] slot_priority
);
   import spq_pkg::*;

   logic [TAG_BITS-1:0]      tag_ff,      tag_in;
   logic [PRIORITY_BITS-1:0] priority_ff, priority_in;
   logic                     occupied;

   assign occupied = fill_count > COUNT_BITS'(CELL_INDEX);
   assign hit      = !occupied || (new_priority > priority_ff);

   always_comb begin
      tag_in      = tag_ff;
      priority_in = priority_ff;
      priority if (ctrl.insert_en) begin
         if (hit) begin
            if (left_hit) begin
               tag_in      = left_tag;
               priority_in = left_priority;
            end else begin
               tag_in      = new_tag;
               priority_in = new_priority;
            end
         end
      end else if (ctrl.remove_en) begin
         tag_in      = right_tag;
         priority_in = right_priority;
      end else begin
         tag_in      = tag_ff;
         priority_in = priority_ff;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff      <= tag_in;
      priority_ff <= priority_in;
   end

   assign slot_tag      = tag_ff;
   assign slot_priority = priority_ff;

endmodule

FILE: rtl/stable_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_queue
// sorted queue of message tags in a chain of slot cells, stable on ties
// ----------------------------------------------------------------------------
// channel  direction  ports                                   handshake
// req      in         opcode, entry_tag, entry_priority       req_valid/req_stall
// rsp      out        accepted, head_tag, head_priority,      rsp_valid/rsp_stall
//                     occupancy
//
// one beat per cycle while req_stall is low: every cell compares and shifts
// in the accepting cycle; the result is registered in the output register,
// or in the second entry of a two-entry output buffer while one result waits
// req_stall rises only when both output entries are full
// reset clears the fill count and output valids; slot contents are not reset
// ----------------------------------------------------------------------------
module stable_priority_queue #(
   parameter int QUEUE_DEPTH   = spq_pkg::DEFAULT_QUEUE_DEPTH,
   parameter int TAG_BITS      = spq_pkg::DEFAULT_TAG_BITS,
   parameter int PRIORITY_BITS = spq_pkg::DEFAULT_PRIORITY_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_opcode,
   input  logic [spq_pkg::TAG_W-1:0]  req_entry_tag,
   input  logic [spq_pkg::PRIO_W-1:0] req_entry_priority,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_accepted,
   output logic [spq_pkg::TAG_W-1:0]  rsp_head_tag,
   output logic [spq_pkg::PRIO_W-1:0] rsp_head_priority,
   output logic [spq_pkg::OCC_W-1:0]  rsp_occupancy
);
   import spq_pkg::*;

   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic [COUNT_BITS-1:0]    count_ff, count_in;
   logic                     accept, take, is_insert, full, empty;
   cell_ctrl_type            ctrl;
   logic [TAG_BITS-1:0]      new_tag;
   logic [PRIORITY_BITS-1:0] new_priority;
   rsp_type                  result;
   rsp_type                  out_ff, skid_ff;
   logic                     out_valid_ff, skid_valid_ff;

   logic                     cell_hit      [QUEUE_DEPTH];
   logic [TAG_BITS-1:0]      cell_tag      [QUEUE_DEPTH];
   logic [PRIORITY_BITS-1:0] cell_priority [QUEUE_DEPTH];

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign take      = out_valid_ff && !rsp_stall;
   assign is_insert = opcode_type'(req_opcode) == OP_INSERT;
   assign full      = count_ff == COUNT_BITS'(QUEUE_DEPTH);
   assign empty     = count_ff == '0;

   assign new_tag      = TAG_BITS'(req_entry_tag);
   assign new_priority = PRIORITY_BITS'(req_entry_priority);

   assign ctrl.insert_en = accept && is_insert && !full;
   assign ctrl.remove_en = accept && !is_insert && !empty;

   always_comb begin
      priority if (ctrl.insert_en) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (ctrl.remove_en) begin
         count_in = count_ff - COUNT_BITS'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_comb begin
      result.accepted      = ctrl.insert_en || ctrl.remove_en;
      result.head_tag      = ctrl.remove_en ? TAG_W'(cell_tag[0]) : '0;
      result.head_priority = ctrl.remove_en ? PRIO_W'(cell_priority[0]) : '0;
      result.occupancy     = OCC_W'(count_in);
   end

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                     left_hit;
      logic [TAG_BITS-1:0]      left_tag, right_tag;
      logic [PRIORITY_BITS-1:0] left_priority, right_priority;

      if (i == 0) begin : g_head
         assign left_hit      = 1'b0;
         assign left_tag      = new_tag;
         assign left_priority = new_priority;
      end else begin : g_body
         assign left_hit      = cell_hit[i-1];
         assign left_tag      = cell_tag[i-1];
         assign left_priority = cell_priority[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_tag      = cell_tag[i];
         assign right_priority = cell_priority[i];
      end else begin : g_inner
         assign right_tag      = cell_tag[i+1];
         assign right_priority = cell_priority[i+1];
      end

      spq_cell #(
         .TAG_BITS      (TAG_BITS),
         .PRIORITY_BITS (PRIORITY_BITS),
         .COUNT_BITS    (COUNT_BITS),
         .CELL_INDEX    (i)
      ) u_cell (
         .clock          (clock),
         .ctrl           (ctrl),
         .fill_count     (count_ff),
         .new_tag        (new_tag),
         .new_priority   (new_priority),
         .left_hit       (left_hit),
         .left_tag       (left_tag),
         .left_priority  (left_priority),
         .right_tag      (right_tag),
         .right_priority (right_priority),
         .hit            (cell_hit[i]),
         .slot_tag       (cell_tag[i]),
         .slot_priority  (cell_priority[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (take) begin
            if (skid_valid_ff) begin
               out_ff        <= skid_ff;
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= accept;
               if (accept) begin
                  out_ff <= result;
               end
            end
         end else if (accept) begin
            if (!out_valid_ff) begin
               out_ff       <= result;
               out_valid_ff <= 1'b1;
            end else begin
               skid_ff       <= result;
               skid_valid_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_accepted      = out_ff.accepted;
   assign rsp_head_tag      = out_ff.head_tag;
   assign rsp_head_priority = out_ff.head_priority;
   assign rsp_occupancy     = out_ff.occupancy;

endmodule

FILE: rtl/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// port-level checks of the stable priority queue, bound to the top level
// ----------------------------------------------------------------------------
`include "stable_priority_queue_macros.svh"

module spq_checker #(
   parameter int QUEUE_DEPTH = spq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       req_opcode,
   input logic [spq_pkg::TAG_W-1:0]  req_entry_tag,
   input logic [spq_pkg::PRIO_W-1:0] req_entry_priority,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic                       rsp_accepted,
   input logic [spq_pkg::TAG_W-1:0]  rsp_head_tag,
   input logic [spq_pkg::PRIO_W-1:0] rsp_head_priority,
   input logic [spq_pkg::OCC_W-1:0]  rsp_occupancy
);
   import spq_pkg::*;

   localparam logic [OCC_W-1:0] DEPTH_OCC = OCC_W'(QUEUE_DEPTH);
   localparam logic             WIDE_DEPTH = QUEUE_DEPTH > (2 ** OCC_W) - 1;

   `SPQ_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall, req_valid && $stable({req_opcode, req_entry_tag, req_entry_priority}), "stalled request beat changed")

   `SPQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable({rsp_accepted, rsp_head_tag, rsp_head_priority, rsp_occupancy}), "stalled result beat changed")

   `SPQ_ASSERT_IMPL(a_reject_zero, clock, reset, rsp_valid && !rsp_accepted, rsp_head_tag == '0 && rsp_head_priority == '0, "rejected beat carries an entry")

   `SPQ_ASSERT_IMPL(a_reject_edge, clock, reset, rsp_valid && !rsp_accepted, rsp_occupancy == '0 || rsp_occupancy == DEPTH_OCC, "rejected beat with queue neither empty nor full")

   `SPQ_ASSERT_IMPL(a_occ_range, clock, reset, rsp_valid, WIDE_DEPTH || rsp_occupancy <= DEPTH_OCC, "occupancy above queue depth")

endmodule

bind stable_priority_queue spq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_spq_checker (.*);

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench for stable_priority_queue
// drives insert and remove beats through a shadow sorted queue and checks
// every result beat field by field; a directed table covers empty, ties and
// the field extremes, then random fill and drain rounds push the queue to
// full and back to empty under random sender gaps and receiver stalls
// ----------------------------------------------------------------------------
module testbench;
   import spq_pkg::*;

   localparam int QUEUE_DEPTH    = 64;
   localparam int RANDOM_BEATS   = 1600;
   localparam int DIRECTED_BEATS = 24;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 8;

   typedef struct packed {
      opcode_type        op;
      logic [TAG_W-1:0]  tag;
      logic [PRIO_W-1:0] prio;
      logic              typed;
      rsp_type           want;
   } stim_row_type;

   // typed rows carry their own expected result, untyped zero rows take it from the shadow queue
   localparam stim_row_type DIRECTED_ROWS [0:DIRECTED_BEATS-1] = '{
      '{OP_REMOVE, 16'hffff, 4'hf, 1'b1, '{1'b0, 16'h0000, 4'h0, 7'd0}},
      '{OP_INSERT, 16'h1111, 4'h5, 1'b1, '{1'b1, 16'h0000, 4'h0, 7'd1}},
      '{OP_INSERT, 16'h2222, 4'h5, 1'b1, '{1'b1, 16'h0000, 4'h0, 7'd2}},
      '{OP_INSERT, 16'hffff, 4'hf, 1'b1, '{1'b1, 16'h0000, 4'h0, 7'd3}},
      '{OP_INSERT, 16'h0000, 4'h0, 1'b1, '{1'b1, 16'h0000, 4'h0, 7'd4}},
      '{OP_INSERT, 16'h3333, 4'h9, 1'b1, '{1'b1, 16'h0000, 4'h0, 7'd5}},
      '{OP_INSERT, 16'h4444, 4'h5, 1'b1, '{1'b1, 16'h0000, 4'h0, 7'd6}},
      '{OP_REMOVE, 16'habcd, 4'h7, 1'b1, '{1'b1, 16'hffff, 4'hf, 7'd5}},
      '{OP_REMOVE, 16'h0000, 4'h0, 1'b1, '{1'b1, 16'h3333, 4'h9, 7'd4}},
      '{OP_REMOVE, 16'h0000, 4'h0, 1'b1, '{1'b1, 16'h1111, 4'h5, 7'd3}},
      '{OP_INSERT, 16'h5555, 4'h5, 1'b1, '{1'b1, 16'h0000, 4'h0, 7'd4}},
      '{OP_INSERT, 16'h6666, 4'h0, 1'b1, '{1'b1, 16'h0000, 4'h0, 7'd5}},
      '{OP_REMOVE, 16'h0000, 4'h0, 1'b1, '{1'b1, 16'h2222, 4'h5, 7'd4}},
      '{OP_REMOVE, 16'h0000, 4'h0, 1'b1, '{1'b1, 16'h4444, 4'h5, 7'd3}},
      '{OP_REMOVE, 16'h0000, 4'h0, 1'b1, '{1'b1, 16'h5555, 4'h5, 7'd2}},
      '{OP_REMOVE, 16'h0000, 4'h0, 1'b1, '{1'b1, 16'h0000, 4'h0, 7'd1}},
      '{OP_REMOVE, 16'h0000, 4'h0, 1'b1, '{1'b1, 16'h6666, 4'h0, 7'd0}},
      '{OP_REMOVE, 16'h5a5a, 4'ha, 1'b1, '{1'b0, 16'h0000, 4'h0, 7'd0}},
      '{OP_INSERT, 16'h8001, 4'h1, 1'b1, '{1'b1, 16'h0000, 4'h0, 7'd1}},
      '{OP_INSERT, 16'h7ffe, 4'he, 1'b0, '0},
      '{OP_INSERT, 16'haaaa, 4'h1, 1'b0, '0},
      '{OP_REMOVE, 16'h0000, 4'h0, 1'b0, '0},
      '{OP_REMOVE, 16'hffff, 4'hf, 1'b0, '0},
      '{OP_REMOVE, 16'h0000, 4'h0, 1'b0, '0}
   };

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_opcode;
   logic [TAG_W-1:0]  req_entry_tag;
   logic [PRIO_W-1:0] req_entry_priority;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_accepted;
   logic [TAG_W-1:0]  rsp_head_tag;
   logic [PRIO_W-1:0] rsp_head_priority;
   logic [OCC_W-1:0]  rsp_occupancy;

   logic [TAG_W-1:0]  held_tag [QUEUE_DEPTH];
   logic [PRIO_W-1:0] held_prio [QUEUE_DEPTH];
   int                held_count = 0;
   rsp_type           pending_results [$];
   int                mismatches = 0;
   int                quiet_cycles = 0;
   int                burst_left = 0;
   int                stall_mode = 0;
   int                stall_left = 0;

   stable_priority_queue u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_entry_tag      (req_entry_tag),
      .req_entry_priority (req_entry_priority),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_accepted       (rsp_accepted),
      .rsp_head_tag       (rsp_head_tag),
      .rsp_head_priority  (rsp_head_priority),
      .rsp_occupancy      (rsp_occupancy)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow sorted queue: insert behind equal priorities, remove from the head
   function automatic rsp_type sorted_queue_step(opcode_type op, logic [TAG_W-1:0] tag,
                                                 logic [PRIO_W-1:0] prio);
      rsp_type res;
      int      pos;
      res = '0;
      if (op == OP_INSERT) begin
         if (held_count < QUEUE_DEPTH) begin
            pos = held_count;
            for (int i = 0; i < held_count && pos == held_count; i++)
               if (prio > held_prio[i]) pos = i;
            for (int i = held_count; i > pos; i--) begin
               held_tag[i]  = held_tag[i-1];
               held_prio[i] = held_prio[i-1];
            end
            held_tag[pos]  = tag;
            held_prio[pos] = prio;
            held_count++;
            res.accepted = 1'b1;
         end
      end else if (held_count > 0) begin
         res.head_tag      = held_tag[0];
         res.head_priority = held_prio[0];
         for (int i = 0; i + 1 < held_count; i++) begin
            held_tag[i]  = held_tag[i+1];
            held_prio[i] = held_prio[i+1];
         end
         held_count--;
         res.accepted = 1'b1;
      end
      res.occupancy = held_count[OCC_W-1:0];
      return res;
   endfunction

   task automatic send_beat(opcode_type op, logic [TAG_W-1:0] tag, logic [PRIO_W-1:0] prio,
                            logic typed, rsp_type want);
      int      gap;
      rsp_type predicted;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 48);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid          <= 1'b1;
      req_opcode         <= op;
      req_entry_tag      <= tag;
      req_entry_priority <= prio;
      do @(posedge clock); while (req_stall);
      predicted = sorted_queue_step(op, tag, prio);
      pending_results.push_back(typed ? want : predicted);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // receiver: free-running, coin-flip or mostly stalled stretches
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_left <= $urandom_range(20, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      unique case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= $urandom_range(0, 1);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result beat with nothing expected");
            mismatches++;
         end else begin
            if (rsp_accepted !== pending_results[0].accepted) begin
               $error("accepted: expected %0d, got %0d",
                      pending_results[0].accepted, rsp_accepted);
               mismatches++;
            end
            if (rsp_head_tag !== pending_results[0].head_tag) begin
               $error("head_tag: expected %h, got %h",
                      pending_results[0].head_tag, rsp_head_tag);
               mismatches++;
            end
            if (rsp_head_priority !== pending_results[0].head_priority) begin
               $error("head_priority: expected %0d, got %0d",
                      pending_results[0].head_priority, rsp_head_priority);
               mismatches++;
            end
            if (rsp_occupancy !== pending_results[0].occupancy) begin
               $error("occupancy: expected %0d, got %0d",
                      pending_results[0].occupancy, rsp_occupancy);
               mismatches++;
            end
            void'(pending_results.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   initial begin
      opcode_type        op;
      logic [PRIO_W-1:0] prio;
      bit                filling;
      bit                narrow;
      int                spills;
      int                spill_target;
      int                prio_base;
      int                round;
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_opcode         <= OP_INSERT;
      req_entry_tag      <= '0;
      req_entry_priority <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_BEATS; r++)
         send_beat(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].tag, DIRECTED_ROWS[r].prio,
                   DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);

      // fill to full and spill over, then drain to empty and spill under
      filling      = 1'b1;
      narrow       = 1'b0;
      spills       = 0;
      spill_target = $urandom_range(1, 4);
      prio_base    = 0;
      round        = 0;
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (filling)
            op = ($urandom_range(0, 99) < 85) ? OP_INSERT : OP_REMOVE;
         else
            op = ($urandom_range(0, 99) < 85) ? OP_REMOVE : OP_INSERT;
         if (filling && op == OP_INSERT && held_count == QUEUE_DEPTH) spills++;
         if (!filling && op == OP_REMOVE && held_count == 0) spills++;
         prio = narrow ? PRIO_W'(prio_base + $urandom_range(0, 1)) : PRIO_W'($urandom_range(0, 15));
         send_beat(op, TAG_W'($urandom_range(0, 16'hffff)), prio, 1'b0, '0);
         if (spills >= spill_target) begin
            filling      = !filling;
            spills       = 0;
            spill_target = $urandom_range(1, 4);
            narrow       = ($urandom_range(0, 2) == 0);
            prio_base    = $urandom_range(0, 14);
            if (round == 0 || $urandom_range(0, 3) == 0) hold_until_drained();
            round++;
         end
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
